/* src/cwre_pkg.sv */
// ----------------------------------------------------------------------------
// cwre_pkg: shared constants and types of the centered window RMS envelope
// Widths, memory geometry, register indexes and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cwre_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int HIST_DEPTH = 128;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int MAX_HALF   = 63;
  localparam int HALF_W     = $clog2(MAX_HALF + 1);
  localparam int POS_W      = 16;
  localparam int WIN_W      = 7;
  localparam int CNT_W      = 7;
  localparam int SQ_W       = 2 * SAMPLE_W;
  localparam int SUM_W      = 37;
  localparam int ROOT_W     = (SUM_W + 1) / 2;
  localparam int RMS_W      = 16;
  localparam int DCNT_W     = $clog2(SUM_W);
  localparam int SCNT_W     = $clog2(ROOT_W);
  localparam int CFG_AW     = 1;
  localparam int CFG_DW     = 16;

  localparam logic [CFG_AW-1:0] CFG_IDX_WINDOW = 1'd0;
  localparam logic [CFG_AW-1:0] CFG_IDX_FRAME  = 1'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic               wr_sample;
    logic [HIST_AW-1:0] wr_addr;
    logic               clr_sum;
    logic               sq_sample;
    logic               sq_mem;
    logic               acc_add;
    logic               acc_sub;
    logic               rd_en;
    logic [HIST_AW-1:0] rd_addr;
    logic               root_start;
    logic [CNT_W-1:0]   count;
    logic               load_out;
    logic               out_last;
  } cwre_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic root_busy;
    logic out_full;
  } cwre_stat_t;

endpackage

`default_nettype wire

/* src/cwre_dp.sv */
// ----------------------------------------------------------------------------
// cwre_dp: datapath of the centered window RMS envelope
// Sample history memory, squarer, running sum of squares, a bit-serial
// divider followed by a bit-serial square root, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cwre_dp (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire cwre_pkg::cwre_cmd_t      cmd,
  output cwre_pkg::cwre_stat_t          stat,
  input  wire [cwre_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [cwre_pkg::RMS_W-1:0]    out_rms,
  output logic                          out_last
);

  logic [cwre_pkg::SAMPLE_W-1:0] hist_mem [cwre_pkg::HIST_DEPTH];
  logic [cwre_pkg::SAMPLE_W-1:0] rdata_r;
  logic [cwre_pkg::SAMPLE_W-1:0] samp_r;
  logic [cwre_pkg::SQ_W-1:0]     sq_r;
  logic [cwre_pkg::SUM_W-1:0]    sum_r;

  logic [cwre_pkg::SUM_W-1:0]    num_r;
  logic [cwre_pkg::CNT_W-1:0]    drem_r;
  logic [cwre_pkg::CNT_W-1:0]    divisor_r;
  logic [cwre_pkg::DCNT_W-1:0]   dcnt_r;
  logic                          div_busy_r;

  logic [2*cwre_pkg::ROOT_W-1:0] rad_r;
  logic [cwre_pkg::ROOT_W:0]     srem_r;
  logic [cwre_pkg::ROOT_W-1:0]   root_r;
  logic [cwre_pkg::SCNT_W-1:0]   scnt_r;
  logic                          sq_busy_r;

  logic                          out_valid_r;
  logic [cwre_pkg::RMS_W-1:0]    out_rms_r;
  logic                          out_last_r;

  logic signed [cwre_pkg::SAMPLE_W-1:0] sq_op;
  logic signed [cwre_pkg::SQ_W-1:0]     sq_prod;
  logic [cwre_pkg::CNT_W:0]             rem_sh;
  logic                                 div_ge;
  logic [cwre_pkg::SUM_W-1:0]           num_nxt;
  logic [cwre_pkg::ROOT_W+2:0]          s_sh;
  logic [cwre_pkg::ROOT_W+2:0]          trial;
  logic                                 sq_ge;
  logic [cwre_pkg::ROOT_W+2:0]          s_diff;
  logic [cwre_pkg::RMS_W-1:0]           rms_sat;

  always_comb begin
    sq_op   = cmd.sq_mem ? rdata_r : samp_r;
    sq_prod = sq_op * sq_op;
    rem_sh  = {drem_r, num_r[cwre_pkg::SUM_W-1]};
    div_ge  = rem_sh >= {1'b0, divisor_r};
    num_nxt = {num_r[cwre_pkg::SUM_W-2:0], div_ge};
    s_sh    = {srem_r, rad_r[2*cwre_pkg::ROOT_W-1 -: 2]};
    trial   = {1'b0, root_r, 2'b01};
    sq_ge   = s_sh >= trial;
    s_diff  = s_sh - trial;
    rms_sat = (|root_r[cwre_pkg::ROOT_W-1:cwre_pkg::RMS_W]) ? '1
                                                             : root_r[cwre_pkg::RMS_W-1:0];
  end

  // History memory: one write and one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_sample) begin
      hist_mem[cmd.wr_addr] <= in_sample;
    end
    if (cmd.rd_en) begin
      rdata_r <= hist_mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_sample) begin
      samp_r <= in_sample;
    end
    if (cmd.sq_sample || cmd.sq_mem) begin
      sq_r <= unsigned'(sq_prod);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (cmd.clr_sum) begin
      sum_r <= '0;
    end else if (cmd.acc_add) begin
      sum_r <= sum_r + {{(cwre_pkg::SUM_W-cwre_pkg::SQ_W){1'b0}}, sq_r};
    end else if (cmd.acc_sub) begin
      sum_r <= sum_r - {{(cwre_pkg::SUM_W-cwre_pkg::SQ_W){1'b0}}, sq_r};
    end
  end

  // Restoring divide of the sum by the window count, one quotient bit per
  // cycle, then a digit-by-digit square root of the quotient, one bit per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      sq_busy_r  <= 1'b0;
    end else if (cmd.root_start) begin
      num_r      <= sum_r;
      drem_r     <= '0;
      divisor_r  <= cmd.count;
      dcnt_r     <= cwre_pkg::DCNT_W'(cwre_pkg::SUM_W - 1);
      div_busy_r <= 1'b1;
    end else if (div_busy_r) begin
      drem_r <= div_ge ? cwre_pkg::CNT_W'(rem_sh - {1'b0, divisor_r})
                       : cwre_pkg::CNT_W'(rem_sh);
      num_r  <= num_nxt;
      dcnt_r <= dcnt_r - 1'b1;
      if (dcnt_r == '0) begin
        div_busy_r <= 1'b0;
        rad_r      <= {{(2*cwre_pkg::ROOT_W-cwre_pkg::SUM_W){1'b0}}, num_nxt};
        srem_r     <= '0;
        root_r     <= '0;
        scnt_r     <= cwre_pkg::SCNT_W'(cwre_pkg::ROOT_W - 1);
        sq_busy_r  <= 1'b1;
      end
    end else if (sq_busy_r) begin
      srem_r <= sq_ge ? s_diff[cwre_pkg::ROOT_W:0] : s_sh[cwre_pkg::ROOT_W:0];
      root_r <= {root_r[cwre_pkg::ROOT_W-2:0], sq_ge};
      rad_r  <= {rad_r[2*cwre_pkg::ROOT_W-3:0], 2'b00};
      scnt_r <= scnt_r - 1'b1;
      if (scnt_r == '0) begin
        sq_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
      out_rms_r   <= rms_sat;
      out_last_r  <= cmd.out_last;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.root_busy = div_busy_r | sq_busy_r;
  assign stat.out_full  = out_valid_r;
  assign out_valid      = out_valid_r;
  assign out_rms        = out_rms_r;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire

/* src/cwre_ctrl.sv */
// ----------------------------------------------------------------------------
// cwre_ctrl: controller of the centered window RMS envelope
// Holds the configuration registers, frame positions and window geometry,
// and steps the datapath through each sample and each result it owes.
// ----------------------------------------------------------------------------
`default_nettype none

module cwre_ctrl (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_we,
  input  wire [cwre_pkg::CFG_AW-1:0]   cfg_addr,
  input  wire [cwre_pkg::CFG_DW-1:0]   cfg_wdata,
  input  wire                          in_valid,
  output logic                         in_ready,
  output cwre_pkg::cwre_cmd_t          cmd,
  input  wire cwre_pkg::cwre_stat_t    stat
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_ACC_SQ, ST_ACC_ADD, ST_LOOP,
    ST_ADD_RD, ST_ADD_SQ, ST_ADD_ACC,
    ST_SUB_RD, ST_SUB_SQ, ST_SUB_ACC,
    ST_ROOT_GO, ST_ROOT_WAIT, ST_EMIT
  } state_t;

  state_t                      state_r;
  logic [cwre_pkg::WIN_W-1:0]  window_r;
  logic [cwre_pkg::POS_W-1:0]  frame_length_r;
  logic [cwre_pkg::POS_W-1:0]  pos_r;
  logic [cwre_pkg::POS_W-1:0]  out_pos_r;
  logic [cwre_pkg::POS_W-1:0]  fl_r;
  logic [cwre_pkg::HALF_W-1:0] half_r;
  logic [cwre_pkg::POS_W-1:0]  top_r;
  logic                        acc_r;
  logic                        last_r;
  logic                        any_r;

  logic [cwre_pkg::POS_W-1:0]  new_fl;
  logic [cwre_pkg::POS_W-1:0]  win_1;
  logic [cwre_pkg::POS_W-1:0]  win_cl;
  logic [cwre_pkg::HALF_W-1:0] new_half;
  logic [cwre_pkg::POS_W-1:0]  cur_fl;
  logic [cwre_pkg::POS_W-1:0]  cur_half;
  logic                        cur_last;
  logic [cwre_pkg::POS_W:0]    right;
  logic [cwre_pkg::POS_W:0]    fl_m1;
  logic [cwre_pkg::POS_W:0]    hi;
  logic [cwre_pkg::POS_W:0]    lo;
  logic [cwre_pkg::POS_W:0]    cnt_full;
  logic                        add_ok;
  logic                        sub_ok;
  logic                        more;
  logic                        accept;

  always_comb begin
    new_fl = (frame_length_r == '0) ? cwre_pkg::POS_W'(1) : frame_length_r;
    win_1  = (window_r == '0) ? cwre_pkg::POS_W'(1)
                              : {{(cwre_pkg::POS_W-cwre_pkg::WIN_W){1'b0}}, window_r};
    win_cl = (win_1 > new_fl) ? new_fl : win_1;
    new_half = (win_cl[cwre_pkg::POS_W-1:1] > cwre_pkg::POS_W'(cwre_pkg::MAX_HALF))
             ? cwre_pkg::HALF_W'(cwre_pkg::MAX_HALF)
             : win_cl[cwre_pkg::HALF_W:1];
    cur_fl   = (pos_r == '0) ? new_fl : fl_r;
    cur_half = {{(cwre_pkg::POS_W-cwre_pkg::HALF_W){1'b0}},
                (pos_r == '0) ? new_half : half_r};
    cur_last = ({1'b0, pos_r} + 1'b1) >= {1'b0, cur_fl};

    right    = {1'b0, out_pos_r} + {{(cwre_pkg::POS_W+1-cwre_pkg::HALF_W){1'b0}}, half_r};
    fl_m1    = {1'b0, fl_r} - 1'b1;
    add_ok   = right < {1'b0, fl_r};
    sub_ok   = out_pos_r > {{(cwre_pkg::POS_W-cwre_pkg::HALF_W){1'b0}}, half_r};
    hi       = (right < fl_m1) ? right : fl_m1;
    lo       = (out_pos_r >= {{(cwre_pkg::POS_W-cwre_pkg::HALF_W){1'b0}}, half_r})
             ? right - {{(cwre_pkg::POS_W-cwre_pkg::HALF_W){1'b0}}, half_r, 1'b0}
             : '0;
    cnt_full = hi - lo + 1'b1;
    more     = any_r && (out_pos_r <= top_r);
    accept   = (state_r == ST_IDLE) && in_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      window_r       <= cwre_pkg::WIN_W'(1);
      frame_length_r <= cwre_pkg::POS_W'(1024);
      pos_r          <= '0;
      out_pos_r      <= '0;
      fl_r           <= cwre_pkg::POS_W'(1);
      half_r         <= '0;
      top_r          <= '0;
      acc_r          <= 1'b0;
      last_r         <= 1'b0;
      any_r          <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          cwre_pkg::CFG_IDX_WINDOW: window_r       <= cfg_wdata[cwre_pkg::WIN_W-1:0];
          cwre_pkg::CFG_IDX_FRAME:  frame_length_r <= cfg_wdata;
          default: ;
        endcase
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            if (pos_r == '0) begin
              fl_r      <= new_fl;
              half_r    <= new_half;
              out_pos_r <= '0;
            end
            acc_r  <= pos_r < cur_half;
            last_r <= cur_last;
            any_r  <= cur_last || (pos_r >= cur_half);
            top_r  <= cur_last ? cur_fl - 1'b1 : pos_r - cur_half;
            state_r <= ST_ACC_SQ;
          end
        end
        ST_ACC_SQ:  state_r <= ST_ACC_ADD;
        ST_ACC_ADD: state_r <= ST_LOOP;
        ST_LOOP: begin
          if (more) begin
            state_r <= ST_ADD_RD;
          end else begin
            if (last_r) begin
              pos_r     <= '0;
              out_pos_r <= '0;
            end else begin
              pos_r <= pos_r + 1'b1;
            end
            state_r <= ST_IDLE;
          end
        end
        ST_ADD_RD:  state_r <= ST_ADD_SQ;
        ST_ADD_SQ:  state_r <= ST_ADD_ACC;
        ST_ADD_ACC: state_r <= ST_SUB_RD;
        ST_SUB_RD:  state_r <= ST_SUB_SQ;
        ST_SUB_SQ:  state_r <= ST_SUB_ACC;
        ST_SUB_ACC: state_r <= ST_ROOT_GO;
        ST_ROOT_GO: state_r <= ST_ROOT_WAIT;
        ST_ROOT_WAIT: begin
          if (!stat.root_busy) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!stat.out_full) begin
            out_pos_r <= out_pos_r + 1'b1;
            state_r   <= ST_LOOP;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.wr_addr    = pos_r[cwre_pkg::HIST_AW-1:0];
    cmd.count      = cnt_full[cwre_pkg::CNT_W-1:0];
    cmd.out_last   = {1'b0, out_pos_r} == fl_m1;
    cmd.rd_addr    = right[cwre_pkg::HIST_AW-1:0];
    unique case (state_r)
      ST_IDLE: begin
        cmd.wr_sample = accept;
        cmd.clr_sum   = accept && (pos_r == '0);
      end
      ST_ACC_SQ:  cmd.sq_sample = 1'b1;
      ST_ACC_ADD: cmd.acc_add   = acc_r;
      ST_LOOP:    cmd.clr_sum   = !more && last_r;
      ST_ADD_RD:  cmd.rd_en     = 1'b1;
      ST_ADD_SQ:  cmd.sq_mem    = 1'b1;
      ST_ADD_ACC: cmd.acc_add   = add_ok;
      ST_SUB_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = out_pos_r[cwre_pkg::HIST_AW-1:0]
                    - {1'b0, half_r} - 1'b1;
      end
      ST_SUB_SQ:  cmd.sq_mem     = 1'b1;
      ST_SUB_ACC: cmd.acc_sub    = sub_ok;
      ST_ROOT_GO: cmd.root_start = 1'b1;
      ST_EMIT:    cmd.load_out   = !stat.out_full;
      default: ;
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);

endmodule

`default_nettype wire

/* src/centered_window_rms_envelope.sv */
// ----------------------------------------------------------------------------
// centered_window_rms_envelope: RMS envelope over a centered, clipped window
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// Each signed input sample yields one RMS value for the window of samples
// i-h .. i+h of its frame, clipped at the frame edges, where h is half the
// window size after it is clamped to the frame length. Results lag the input
// by h words, and the last word of a frame flushes the h+1 results still
// owed; the final result of a frame carries tlast. Both registers are
// latched when the first word of a frame arrives, so writes take effect at
// the next frame. The block works on one input word at a time and releases
// the results that a word owes one after another; a result may also wait
// for the output register to empty. The time for each result is set by the
// shared divider, one quotient bit at a time, and square root, one root bit
// at a time, plus the reads, squares and sum updates through the single read
// port of the sample history memory and the hand-off between the steps.
// A finished result waits in the output register while the block goes on
// with the next word.
// ----------------------------------------------------------------------------
`default_nettype none

module centered_window_rms_envelope (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_we,
  input  wire [cwre_pkg::CFG_AW-1:0]   cfg_addr,
  input  wire [cwre_pkg::CFG_DW-1:0]   cfg_wdata,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire [15:0]                   in_tdata,   // [15:0] sample
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [15:0]                  out_tdata,  // [15:0] rms_value
  output logic                         out_tlast   // frame_end
);

  cwre_pkg::cwre_cmd_t  cmd;
  cwre_pkg::cwre_stat_t stat;

  // The controller owns all positions and window geometry.
  cwre_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // The datapath holds the history, the sum of squares and the root unit.
  cwre_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_sample (in_tdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_rms   (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

`default_nettype wire

/* src/cwre_checker.sv */
// ----------------------------------------------------------------------------
// cwre_checker: port-level checks of the centered window RMS envelope
// Watches the top-level ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
`default_nettype none

module cwre_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [15:0] out_tdata
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // One word is worked on at a time: after an accept the input is closed.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while busy");

  // An RMS of 16-bit samples never exceeds full scale.
  a_rms_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata <= 16'd32768)
    else $error("rms value out of range");

  // Reset empties the output and opens the input.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("bad state after reset");

endmodule

bind centered_window_rms_envelope cwre_checker u_cwre_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the centered window RMS envelope
// Sends signed sample words in frames through the input stream and predicts
// every RMS result with a behavioral model of the windowed mean square. Each
// output word is compared field by field with the oldest prediction. Register
// writes happen only while the block is idle. Idle and stall rates vary from
// one phase to the next.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [15:0] rms;
    logic        frame_end;
  } envelope_t;

  typedef enum {ROW_CFG, ROW_WORD, ROW_DRAIN} row_kind_t;

  typedef struct {
    row_kind_t                   kind;
    logic [cwre_pkg::CFG_AW-1:0] idx;
    logic [15:0]                 value;
    bit                          has_rms;
    logic [15:0]                 rms;
  } row_t;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_we;
  logic [cwre_pkg::CFG_AW-1:0] cfg_addr;
  logic [cwre_pkg::CFG_DW-1:0] cfg_wdata;
  logic                        in_tvalid;
  logic                        in_tready;
  logic [15:0]                 in_tdata;   // [15:0] sample
  logic                        out_tvalid;
  logic                        out_tready;
  logic [15:0]                 out_tdata;  // [15:0] rms_value
  logic                        out_tlast;  // frame_end

  centered_window_rms_envelope i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // Register copies as the bench wrote them, plus the per-frame state that
  // the block latches when the first word of a frame arrives.
  logic [6:0]         window_reg;
  logic [15:0]        frame_reg;
  logic signed [15:0] sample_hist [cwre_pkg::HIST_DEPTH];
  logic [63:0]        energy_sum;
  int unsigned        next_in_pos;
  int unsigned        next_out_pos;
  int unsigned        active_len;
  int unsigned        active_half;

  envelope_t   envelope_q[$];
  logic [15:0] newest_rms;
  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned error_count;
  int unsigned idle_pct;
  int unsigned stall_pct;
  row_t        directed_rows[$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("Timeout with %0d results still owed.", envelope_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH %s", $realtime, what);
    error_count++;
  endtask

  function automatic logic [63:0] square_of(input logic signed [15:0] s);
    logic [63:0] mag;
    mag = (s < 0) ? 64'(-32'(s)) : 64'(s);
    return mag * mag;
  endfunction

  // Bitwise integer square root, two bits of the radicand per step.
  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x    = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Works out every RMS result that one accepted sample word releases.
  function automatic void predict_envelope(input logic [15:0] raw);
    logic signed [15:0] s;
    int unsigned        p, w, top, i, right, lo, hi, count, n;
    bit                 last, any;
    logic [63:0]        rms;
    s = raw;
    p = next_in_pos;
    n = 0;
    if (p == 0) begin
      active_len = (frame_reg == 0) ? 1 : frame_reg;
      w = window_reg;
      if (w < 1) w = 1;
      if (w > active_len) w = active_len;
      active_half = w / 2;
      if (active_half > cwre_pkg::MAX_HALF) active_half = cwre_pkg::MAX_HALF;
      energy_sum   = 0;
      next_out_pos = 0;
    end
    sample_hist[p % cwre_pkg::HIST_DEPTH] = s;
    if (p < active_half) energy_sum += square_of(s);
    last = (p + 1 >= active_len);
    any  = last || (p >= active_half);
    top  = last ? active_len - 1 : p - active_half;
    while (any && next_out_pos <= top && n < cwre_pkg::MAX_HALF + 1) begin
      i     = next_out_pos;
      right = i + active_half;
      if (right < active_len)
        energy_sum += square_of(sample_hist[right % cwre_pkg::HIST_DEPTH]);
      if (i >= active_half + 1)
        energy_sum -= square_of(sample_hist[(i - active_half - 1) % cwre_pkg::HIST_DEPTH]);
      hi    = (right < active_len - 1) ? right : active_len - 1;
      lo    = (i >= active_half) ? i - active_half : 0;
      count = hi - lo + 1;
      rms   = int_sqrt(energy_sum / count);
      if (rms > 64'hFFFF) rms = 64'hFFFF;
      newest_rms = rms[15:0];
      envelope_q.push_back('{rms[15:0], i == active_len - 1});
      n++;
      next_out_pos++;
    end
    next_in_pos = last ? 0 : p + 1;
    if (last) energy_sum = 0;
  endfunction

  // Both handshakes are observed at the rising edge, before the block's own
  // register updates land.
  always @(posedge clk) begin
    envelope_t want;
    if (rst_n && in_tvalid && in_tready) begin
      predict_envelope(in_tdata);
      words_sent++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      words_checked++;
      if (envelope_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result rms=%0d last=%0b", out_tdata,
                                  out_tlast));
      end else begin
        want = envelope_q.pop_front();
        if (out_tdata !== want.rms)
          report_mismatch($sformatf("rms got %0d want %0d", out_tdata, want.rms));
        if (out_tlast !== want.frame_end)
          report_mismatch($sformatf("tlast got %0b want %0b", out_tlast, want.frame_end));
      end
    end
  end

  // The receiver stalls at random, at the rate of the current phase.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic write_reg(input logic [cwre_pkg::CFG_AW-1:0] idx,
                           input logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    if (idx == cwre_pkg::CFG_IDX_WINDOW) window_reg = value[6:0];
    else frame_reg = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Returns right after the word is taken, with tvalid still high, so the
  // next word can follow at once; callers drop tvalid before anything else.
  task automatic send_word(input logic [15:0] value);
    int unsigned target;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    target = words_sent + 1;
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    do @(negedge clk); while (words_sent < target);
  endtask

  // Waits until every owed result has come, then lets a word that releases
  // nothing finish inside the block.
  task automatic wait_idle();
    while (envelope_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic add_row(input row_kind_t kind, input logic [15:0] value,
                         input logic [cwre_pkg::CFG_AW-1:0] idx = cwre_pkg::CFG_IDX_WINDOW,
                         input bit has_rms = 0, input logic [15:0] rms = 0);
    directed_rows.push_back('{kind, idx, value, has_rms, rms});
  endtask

  task automatic send_frame(input int unsigned len, input int unsigned phase);
    case (phase % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 47; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 47; end
      default: begin idle_pct = 26; stall_pct = 26; end
    endcase
    repeat (len) send_word(16'($urandom_range(16'hFFFF)));
    in_tvalid <= 1'b0;
  endtask

  initial begin
    int unsigned phase;
    int unsigned len;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_addr    = cwre_pkg::CFG_IDX_WINDOW;
    cfg_wdata   = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    idle_pct    = 0;
    stall_pct   = 0;
    error_count = 0;
    words_sent  = 0;
    words_checked = 0;
    window_reg  = 7'd1;
    frame_reg   = 16'd1024;
    energy_sum  = 0;
    next_in_pos = 0;
    next_out_pos = 0;
    active_len  = 1;
    active_half = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. With one-word frames the RMS is just the magnitude of
    // the sample, which covers both extremes and a zero window size.
    add_row(ROW_CFG, 16'd1, cwre_pkg::CFG_IDX_FRAME);
    add_row(ROW_CFG, 16'd0, cwre_pkg::CFG_IDX_WINDOW);
    add_row(ROW_WORD, 16'h0000, , 1, 16'd0);
    add_row(ROW_WORD, 16'h7FFF, , 1, 16'd32767);
    add_row(ROW_WORD, 16'h8000, , 1, 16'd32768);
    add_row(ROW_WORD, 16'hFFFF, , 1, 16'd1);
    add_row(ROW_WORD, 16'h0001, , 1, 16'd1);
    add_row(ROW_WORD, 16'h5555, , 1, 16'd21845);
    add_row(ROW_WORD, 16'hAAAA, , 1, 16'd21846);
    add_row(ROW_DRAIN, 16'd0);
    // A zero frame length acts as a length of one.
    add_row(ROW_CFG, 16'd0, cwre_pkg::CFG_IDX_FRAME);
    add_row(ROW_WORD, 16'h8000, , 1, 16'd32768);
    add_row(ROW_DRAIN, 16'd0);
    // Window far longer than the frame gets clamped to it; all bits written.
    add_row(ROW_CFG, 16'd5, cwre_pkg::CFG_IDX_FRAME);
    add_row(ROW_CFG, 16'hFFFF, cwre_pkg::CFG_IDX_WINDOW);
    add_row(ROW_WORD, 16'h7FFF);
    add_row(ROW_WORD, 16'h8000);
    add_row(ROW_WORD, 16'h1234);
    add_row(ROW_WORD, 16'hFEDC);
    add_row(ROW_WORD, 16'h0F0F);
    add_row(ROW_DRAIN, 16'd0);
    // A window write in the middle of a frame only counts from the next one.
    add_row(ROW_CFG, 16'd8, cwre_pkg::CFG_IDX_FRAME);
    add_row(ROW_CFG, 16'd3, cwre_pkg::CFG_IDX_WINDOW);
    add_row(ROW_WORD, 16'h4000);
    add_row(ROW_DRAIN, 16'd0);
    add_row(ROW_CFG, 16'hFF89, cwre_pkg::CFG_IDX_WINDOW);
    for (int k = 0; k < 7; k++) add_row(ROW_WORD, 16'h3000 + 16'(k * 16'h1111));
    add_row(ROW_DRAIN, 16'd0);

    foreach (directed_rows[k]) begin
      case (directed_rows[k].kind)
        ROW_CFG: begin
          in_tvalid <= 1'b0;
          write_reg(directed_rows[k].idx, directed_rows[k].value);
        end
        ROW_WORD: begin
          send_word(directed_rows[k].value);
          if (directed_rows[k].has_rms && newest_rms !== directed_rows[k].rms)
            report_mismatch($sformatf("row %0d predicts %0d, table says %0d", k,
                                      newest_rms, directed_rows[k].rms));
        end
        default: begin
          in_tvalid <= 1'b0;
          wait_idle();
        end
      endcase
    end

    // Random part. The first frame runs the largest window the frame allows,
    // so its last word flushes a long run of results.
    phase = 0;
    write_reg(cwre_pkg::CFG_IDX_FRAME, 16'd64);
    write_reg(cwre_pkg::CFG_IDX_WINDOW, 16'd127);
    send_frame(64, phase++);
    wait_idle();
    while (phase < 4 || words_sent < 110) begin
      len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 24);
      write_reg(cwre_pkg::CFG_IDX_FRAME, 16'(len));
      write_reg(cwre_pkg::CFG_IDX_WINDOW, 16'($urandom_range(16'hFFFF)));
      send_frame(len, phase++);
      // The sender holds off here until every owed result is out.
      wait_idle();
    end
    // The longest frame is opened but only partly sent.
    write_reg(cwre_pkg::CFG_IDX_FRAME, 16'hFFFF);
    write_reg(cwre_pkg::CFG_IDX_WINDOW, 16'd9);
    send_frame(8, phase++);

    wait_idle();
    repeat (200) @(negedge clk);
    $display("Sent %0d sample words and checked %0d RMS results over frames of",
             words_sent, words_checked);
    $display("length 0 to 65535, windows 0 to 127, under four idle/stall phases.");
    if (error_count == 0 && envelope_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
